// ===== design/bat_pkg.sv =====
// shared types and constants for the breakpoint address table
// command and status codes, the request token that walks the cell chain
// no dependencies
package bat_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ADDR_W = 16;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int USED_W = 5;

	localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL_OR_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_ADDR = 2'd3;

	// request as it travels from cell to cell
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic              act;   // add allowed: address nonzero and table not full
		logic              found; // an earlier cell matched or took the add
	} bat_tok_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [USED_W-1:0]   entries_used;
	} bat_res_t;

endpackage

// ===== design/breakpoint_address_table.sv =====
// breakpoint address table: a chain of TABLE_DEPTH cells, one entry each
// a request walks the chain one cell per cycle; its result is registered
// once the token leaves the last cell, held pending if the output is stalled
// one request at a time: the next is taken once the result is registered
// and no result is pending, so a new request waits for the last to finish
// reset clears all valid bits and the count at once; no clearing sweep
module breakpoint_address_table #(
	parameter int TABLE_DEPTH = bat_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bat_pkg::CMD_W-1:0]    command,
	input  logic [bat_pkg::ADDR_W-1:0]   address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bat_pkg::STATUS_W-1:0] status,
	output logic                         hit,
	output logic [bat_pkg::USED_W-1:0]   entries_used
);
	import bat_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic               busy_q;
	logic               accept;
	logic [TABLE_DEPTH:0]   tok_vld;
	bat_tok_t           tok [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] cell_vld;
	bat_tok_t           tok_end;
	logic               tok_end_vld;
	bat_res_t           res;
	bat_res_t           out_q;
	logic               out_vld_q;
	bat_res_t           pend_q;
	logic               pend_vld_q;
	logic [31:0]        cnt_ext;

	assign in_ready = !busy_q && !pend_vld_q;
	assign accept = in_valid && in_ready;

	always_comb begin
		tok[0].cmd = command;
		tok[0].addr = address;
		tok[0].act = (command == CMD_ADD) && (address != '0)
			&& (count_q < CNT_W'(TABLE_DEPTH));
		tok[0].found = 1'b0;
	end
	assign tok_vld[0] = accept;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		bat_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_vld_i (tok_vld[i]),
			.tok_i     (tok[i]),
			.tok_vld_o (tok_vld[i+1]),
			.tok_o     (tok[i+1]),
			.vld_o     (cell_vld[i])
		);
	end

	assign tok_end = tok[TABLE_DEPTH];
	assign tok_end_vld = tok_vld[TABLE_DEPTH];

	// count does not move while a request is in the chain
	always_comb begin
		count_nxt = count_q;
		res.status = ST_OK;
		res.hit = 1'b0;
		case (tok_end.cmd)
			CMD_ADD: begin
				if (tok_end.addr == '0) begin
					res.status = ST_ZERO_ADDR;
				end else if (!tok_end.act) begin
					res.status = ST_FULL_OR_MISS;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (tok_end.addr == '0) begin
					res.status = ST_ZERO_ADDR;
				end else if (tok_end.found) begin
					count_nxt = count_q - CNT_W'(1);
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			CMD_CHECK: begin
				if (tok_end.found) begin
					res.hit = 1'b1;
				end else begin
					res.status = ST_FULL_OR_MISS;
				end
			end
			default: begin
			end
		endcase
		cnt_ext = 32'(count_nxt);
		res.entries_used = cnt_ext[USED_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q <= 1'b0;
			out_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tok_end_vld) begin
				busy_q <= 1'b0;
			end
			if (tok_end_vld) begin
				count_q <= count_nxt;
				if (!out_vld_q || out_ready) begin
					out_vld_q <= 1'b1;
				end else begin
					pend_vld_q <= 1'b1;
				end
			end else if (pend_vld_q && out_ready) begin
				pend_vld_q <= 1'b0;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end_vld) begin
			if (!out_vld_q || out_ready) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end else if (pend_vld_q && out_ready) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_vld_q;
	assign status = out_q.status;
	assign hit = out_q.hit;
	assign entries_used = out_q.entries_used;

	// a single request in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld[TABLE_DEPTH:1]))
		else $error("more than one request in the cell chain");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// between requests the valid bits agree with the count
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> ($countones(cell_vld) == int'(count_q)))
		else $error("valid bits disagree with entry count");

	assert property (@(posedge clk) disable iff (!arst_n)
		tok_end_vld |-> !pend_vld_q)
		else $error("result finished while another result is pending");

endmodule

// ===== design/bat_cell.sv =====
// one slot of the breakpoint table: entry register, valid bit, token stage
// the request token passes through one cell per cycle
// depends on bat_pkg
module bat_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_vld_i,
	input  bat_pkg::bat_tok_t tok_i,
	output logic              tok_vld_o,
	output bat_pkg::bat_tok_t tok_o,
	output logic              vld_o
);
	import bat_pkg::*;

	logic [ADDR_W-1:0] entry_q;
	logic              vld_q;
	logic              tok_vld_q;
	bat_tok_t          tok_q;
	bat_tok_t          tok_nxt;
	logic              match;
	logic              take_add;
	logic              take_rem;

	always_comb begin
		match = vld_q && (entry_q == tok_i.addr);
		tok_nxt = tok_i;
		take_add = 1'b0;
		take_rem = 1'b0;
		case (tok_i.cmd)
			CMD_ADD: begin
				if (tok_i.act && !tok_i.found && !vld_q) begin
					take_add = 1'b1;
					tok_nxt.found = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!tok_i.found && match) begin
					take_rem = 1'b1;
					tok_nxt.found = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (match) begin
					tok_nxt.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_i;
			if (tok_vld_i && take_add) begin
				vld_q <= 1'b1;
			end else if (tok_vld_i && take_rem) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld_i) begin
			tok_q <= tok_nxt;
			if (take_add) begin
				entry_q <= tok_i.addr;
			end
		end
	end

	assign tok_vld_o = tok_vld_q;
	assign tok_o = tok_q;
	assign vld_o = vld_q;

endmodule

// ===== dv/breakpoint_address_table_tb.sv =====
// testbench for breakpoint_address_table: directed and random add, remove and check requests
// predicts every result from its own copy of the table and checks it field by field
// depends on bat_pkg and breakpoint_address_table
module breakpoint_address_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bat_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 1000;
	localparam int POOL_SIZE = 12;
	localparam int PHASE_ITEMS = 61;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    command = CMD_CHECK;
	logic [ADDR_W-1:0]   address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                hit;
	logic [USED_W-1:0]   entries_used;

	// predicted table contents and the results still owed by the block
	logic [ADDR_W-1:0] bp_slot [DEPTH];
	int                bp_used = 0;
	bat_res_t          pending_results [$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	bit rush = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int ready_wait = 0;
	int fail_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int hits_seen = 0;
	int full_seen = 0;
	int not_found_seen = 0;

	breakpoint_address_table #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.address(address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.hit(hit),
		.entries_used(entries_used)
	);

	always #10 clk = ~clk;

	function automatic bat_res_t predict_result(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
		bat_res_t r;
		int idx;
		r.status = ST_OK;
		r.hit = 1'b0;
		idx = -1;
		case (cmd)
			CMD_ADD: begin
				if (addr == '0) begin
					r.status = ST_ZERO_ADDR;
				end else if (bp_used >= DEPTH) begin
					r.status = ST_FULL_OR_MISS;
				end else begin
					bp_slot[bp_used] = addr;
					bp_used++;
				end
			end
			CMD_REMOVE: begin
				if (addr == '0) begin
					r.status = ST_ZERO_ADDR;
				end else begin
					for (int k = 0; k < bp_used; k++)
						if (idx < 0 && bp_slot[k] == addr)
							idx = k;
					if (idx < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						// last entry fills the hole
						bp_slot[idx] = bp_slot[bp_used - 1];
						bp_slot[bp_used - 1] = '0;
						bp_used--;
					end
				end
			end
			CMD_CHECK: begin
				for (int k = 0; k < bp_used; k++)
					if (bp_slot[k] == addr)
						r.hit = 1'b1;
				r.status = r.hit ? ST_OK : ST_FULL_OR_MISS;
			end
			default: ;
		endcase
		r.entries_used = bp_used[USED_W-1:0];
		return r;
	endfunction

	function automatic int draw_wait();
		return rush ? 0 : int'($urandom_range(0, 9));
	endfunction

	// mostly addresses that are or were in the table, some zero, some anything
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 22)
			return ADDR_W'($urandom);
		if (r < 60 && bp_used > 0)
			return bp_slot[$urandom_range(bp_used - 1, 0)];
		return addr_pool[$urandom_range(POOL_SIZE - 1, 0)];
	endfunction

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// starts and ends at a rising edge; valid stays up across back-to-back requests
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		address <= addr;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_result(cmd, addr));
		sent_count++;
	endtask

	task automatic test_empty_table();
		send_request(CMD_CHECK, 16'h0000);
		send_request(CMD_REMOVE, 16'h1234);
		send_request(CMD_REMOVE, 16'h0000);
		send_request(CMD_ADD, 16'h0000);
		send_request(CMD_UNUSED, 16'hFFFF);
	endtask

	task automatic test_fill_to_capacity();
		send_request(CMD_ADD, 16'hFFFF);
		send_request(CMD_ADD, 16'h0001);
		send_request(CMD_ADD, 16'h8000);
		send_request(CMD_ADD, 16'h0001);
		for (int k = 1; k <= DEPTH - 4; k++)
			send_request(CMD_ADD, ADDR_W'(16'h0100 * k + 16'h0042));
		send_request(CMD_ADD, 16'h5555);
		send_request(CMD_CHECK, 16'h0000);
		send_request(CMD_CHECK, 16'hFFFF);
	endtask

	// the duplicate survives the first remove, which takes the lower slot
	task automatic test_remove_order();
		send_request(CMD_REMOVE, 16'h0001);
		send_request(CMD_CHECK, 16'h0001);
		send_request(CMD_REMOVE, 16'h0001);
		send_request(CMD_CHECK, 16'h0001);
		send_request(CMD_REMOVE, 16'hFFFF);
	endtask

	task automatic test_output_backpressure();
		hold_req = 1'b1;
		rush = 1'b1;
		repeat (12) send_request(CMD_W'($urandom_range(0, 2)), pick_address());
		rush = 1'b0;
	endtask

	// alternate fill-heavy and drain-heavy phases so the count sweeps empty to full
	task automatic test_random_traffic();
		int unsigned r;
		int add_pct;
		int remove_pct;
		logic [CMD_W-1:0] cmd;
		for (int phase = 0; phase < 10; phase++) begin
			add_pct = (phase % 2 == 0) ? 55 : 20;
			remove_pct = (phase % 2 == 0) ? 15 : 45;
			rush = (phase == 3 || phase == 8);
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					cmd = CMD_UNUSED;
				else if (r < 3 + add_pct)
					cmd = CMD_ADD;
				else if (r < 3 + add_pct + remove_pct)
					cmd = CMD_REMOVE;
				else
					cmd = CMD_CHECK;
				send_request(cmd, pick_address());
			end
		end
		rush = 1'b0;
	endtask

	// receiver: random stall after each result, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_wait = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			ready_wait = draw_wait();
			out_ready <= (ready_wait == 0);
		end else if (ready_wait > 0) begin
			ready_wait--;
			out_ready <= (ready_wait == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		bat_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: status %0d hit %0d entries_used %0d",
					status, hit, entries_used);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", 8'(want.status), 8'(status));
				compare_field("hit", 8'(want.hit), 8'(hit));
				compare_field("entries_used", 8'(want.entries_used), 8'(entries_used));
				checked_count++;
				if (want.hit)
					hits_seen++;
				if (want.status == ST_FULL_OR_MISS && !want.hit && bp_used == DEPTH)
					full_seen++;
				if (want.status == ST_NOT_FOUND)
					not_found_seen++;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no handshake for %0d cycles", quiet);
		$display("breakpoint_address_table_tb NOT OK");
		$finish;
	end

	initial begin
		foreach (bp_slot[k])
			bp_slot[k] = '0;
		foreach (addr_pool[k])
			addr_pool[k] = ADDR_W'($urandom_range(16'hFFFF, 1));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_to_capacity();
		test_remove_order();
		test_output_backpressure();
		test_random_traffic();

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		$display("%0d requests checked across empty, full and draining tables, with back-to-back",
			checked_count);
		$display("traffic and a long output stall: %0d hits, %0d not-found removes, %0d sent",
			hits_seen, not_found_seen, sent_count);
		if (fail_count == 0)
			$display("breakpoint_address_table_tb OK");
		else
			$display("breakpoint_address_table_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bat_pkg.sv
design/bat_cell.sv
design/breakpoint_address_table.sv
dv/breakpoint_address_table_tb.sv
